// ===== rtl/iq_ssb_am_demodulator_unit_defines.svh =====
// assertion macros used by the checker file
`ifndef IQ_SSB_AM_DEMODULATOR_UNIT_DEFINES_SVH
`define IQ_SSB_AM_DEMODULATOR_UNIT_DEFINES_SVH

// consequent checked in the cycle after the antecedent
`define IQSSB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// antecedent and consequent in the same cycle
`define IQSSB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/iqssb_pkg.sv =====
// ----------------------------------------------------------------------------
// iqssb_pkg
// types, constants and coefficient tables of the iq ssb/am demodulator
// ----------------------------------------------------------------------------
package iqssb_pkg;

  localparam int DAC_FULL_SCALE = 4096;
  localparam int ADC_FULL_SCALE = 4096;
  localparam int TAPS           = 15;
  localparam int LP_TAPS        = 8;
  localparam int HB_TAPS        = 4;

  localparam logic [12:0]        ADC_MIDSCALE = 13'(ADC_FULL_SCALE / 2);
  localparam logic signed [16:0] DAC_MIDSCALE = 17'(DAC_FULL_SCALE / 2);
  localparam logic signed [16:0] DAC_TOP      = 17'(DAC_FULL_SCALE);

  localparam logic [1:0] MODE_USB  = 2'd0;
  localparam logic [1:0] MODE_LSB  = 2'd1;
  localparam logic [1:0] MODE_AM   = 2'd2;
  localparam logic [1:0] MODE_MUTE = 2'd3;

  localparam logic REG_DEMOD_MODE = 1'b0;
  localparam logic REG_AUDIO_GAIN = 1'b1;

  typedef logic signed [15:0] sample16_t;

  typedef struct packed {
    logic [11:0] i_raw;
    logic [11:0] q_raw;
    logic        clear_monitors;
  } in_item_t;

  typedef struct packed {
    logic [12:0]        dac_level;
    logic               clip_now;
    logic               clip_seen;
    logic [14:0]        input_peak;
    logic [14:0]        output_peak;
    logic signed [11:0] i_dc;
    logic signed [11:0] q_dc;
  } out_item_t;

  typedef struct packed {
    logic [1:0]        demod_mode;
    logic signed [7:0] gain;
  } merge_cfg_t;

  typedef struct packed {
    logic [12:0] dac_level;
    logic        clip_now;
    logic        clip_seen;
    logic [14:0] input_peak;
    logic [14:0] output_peak;
  } merge_res_t;

  function automatic logic signed [13:0] lp_coef(input logic [2:0] idx);
    logic signed [13:0] c;
    case (idx)
      3'd0:    c = -14'sd86;
      3'd1:    c = 14'sd18;
      3'd2:    c = 14'sd488;
      3'd3:    c = 14'sd1404;
      3'd4:    c = 14'sd2669;
      3'd5:    c = 14'sd3998;
      3'd6:    c = 14'sd5013;
      default: c = 14'sd5394;
    endcase
    return c;
  endfunction

  function automatic logic signed [15:0] hb_coef(input logic [1:0] idx);
    logic signed [15:0] c;
    case (idx)
      2'd0:    c = 16'sd2980;
      2'd1:    c = 16'sd4172;
      2'd2:    c = 16'sd6953;
      default: c = 16'sd20860;
    endcase
    return c;
  endfunction

  // magnitude of a 16-bit value, saturated to 15 bits
  function automatic logic [14:0] mag_sat16(input logic signed [15:0] v);
    logic [15:0] m;
    m = v[15] ? 16'(-v) : 16'(v);
    return m[15] ? 15'h7fff : m[14:0];
  endfunction

endpackage

// ===== rtl/iq_ssb_am_demodulator_unit.sv =====
// ----------------------------------------------------------------------------
// iq_ssb_am_demodulator_unit
// flow: an input transfer passes the lanes, then the merge, then the output
//   register; a negative gain adds the bit-serial divide in the merge
// one item in flight: a new transfer is taken only once the result has moved
//   to the output register, so the pace is set by the one-multiplier lowpass
//   loop, the hilbert loop, the bit-serial divider and a stalled output
// reset: synchronous, clears dc estimates, delay lines, monitors and config registers
// ----------------------------------------------------------------------------
module iq_ssb_am_demodulator_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  iqssb_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output iqssb_pkg::out_item_t out_item,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [7:0]           cfg_data
);
  import iqssb_pkg::*;

  // top sequencer: idle, lanes filtering, merge running, result waiting
  typedef enum logic [3:0] {
    T_IDLE  = 4'b0001,
    T_LANE  = 4'b0010,
    T_MERGE = 4'b0100,
    T_OUT   = 4'b1000
  } tstate_t;

  tstate_t            state;
  logic [1:0]         demod_mode;
  logic signed [7:0]  gain_setting;
  logic               clear_hold;
  logic               lane_start;
  logic               merge_start;
  logic               done_i;
  logic               done_q;
  logic               merge_done;
  logic               out_load;
  logic signed [11:0] i_dc;
  logic signed [11:0] q_dc;
  sample16_t          i_line [TAPS];
  sample16_t          q_line [TAPS];
  merge_cfg_t         mcfg;
  merge_res_t         mres;

  // one item in flight; the output register lets the next transfer in
  assign in_ready    = (state == T_IDLE);
  assign lane_start  = (state == T_IDLE) && in_valid;
  assign merge_start = (state == T_LANE) && done_i && done_q;
  assign out_load    = (state == T_OUT) && (!out_valid || out_ready);
  assign mcfg        = '{demod_mode: demod_mode, gain: gain_setting};

  // in-phase and quadrature lanes run side by side
  iqssb_lane u_lane_i (
    .clk    (clk),
    .rst    (rst),
    .start  (lane_start),
    .raw    (in_item.i_raw),
    .done   (done_i),
    .dc_est (i_dc),
    .fline  (i_line)
  );

  iqssb_lane u_lane_q (
    .clk    (clk),
    .rst    (rst),
    .start  (lane_start),
    .raw    (in_item.q_raw),
    .done   (done_q),
    .dc_est (q_dc),
    .fline  (q_line)
  );

  // merge holds its result until the next start
  iqssb_merge u_merge (
    .clk    (clk),
    .rst    (rst),
    .start  (merge_start),
    .clear  (clear_hold),
    .cfg    (mcfg),
    .i_line (i_line),
    .q_line (q_line),
    .done   (merge_done),
    .res    (mres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= T_IDLE;
      out_valid    <= 1'b0;
      demod_mode   <= MODE_USB;
      gain_setting <= '0;
    end else begin
      // the user must write the registers only while idle; the block does not enforce it
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DEMOD_MODE: demod_mode <= cfg_data[1:0];
          REG_AUDIO_GAIN: gain_setting <= $signed(cfg_data);
          default: ;
        endcase
      end
      // a new result replaces the one taken in the same cycle
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        T_IDLE:  if (in_valid) state <= T_LANE;
        T_LANE:  if (done_i && done_q) state <= T_MERGE;
        T_MERGE: if (merge_done) state <= T_OUT;
        T_OUT:   if (!out_valid || out_ready) state <= T_IDLE;
        default: state <= T_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (lane_start) clear_hold <= in_item.clear_monitors;
    if (out_load) begin
      out_item.dac_level   <= mres.dac_level;
      out_item.clip_now    <= mres.clip_now;
      out_item.clip_seen   <= mres.clip_seen;
      out_item.input_peak  <= mres.input_peak;
      out_item.output_peak <= mres.output_peak;
      out_item.i_dc        <= i_dc;
      out_item.q_dc        <= q_dc;
    end
  end

endmodule

// ===== rtl/iqssb_lane.sv =====
// ----------------------------------------------------------------------------
// iqssb_lane
// one channel: re-centering, dc tracking and 15-tap lowpass, one tap pair a cycle
// ----------------------------------------------------------------------------
module iqssb_lane (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [11:0]          raw,
  output logic                 done,
  output logic signed [11:0]   dc_est,
  output iqssb_pkg::sample16_t fline [iqssb_pkg::TAPS]
);
  import iqssb_pkg::*;

  logic signed [12:0] rline [TAPS];
  logic signed [12:0] rnew  [TAPS];
  logic signed [13:0] pre      [LP_TAPS];
  logic signed [13:0] pre_next [LP_TAPS];
  logic signed [28:0] acc;
  logic signed [28:0] acc_next;
  logic signed [27:0] prod;
  logic [2:0]         step;
  logic               busy;
  logic signed [12:0] s;
  logic signed [12:0] s_adj;
  logic signed [11:0] dc_adj;
  logic signed [11:0] dc_next;
  logic signed [12:0] x;
  sample16_t          fout;

  always_comb begin
    s       = $signed({1'b0, raw} - ADC_MIDSCALE);
    s_adj   = s + (s[12] ? 13'sd127 : 13'sd0);
    dc_adj  = dc_est + (dc_est[11] ? 12'sd127 : 12'sd0);
    dc_next = dc_est + 12'(s_adj >>> 7) - 12'(dc_adj >>> 7);
    x       = 13'(s - dc_next);
    for (int k = 0; k < TAPS - 1; k++) rnew[k] = rline[k + 1];
    rnew[TAPS - 1] = x;
    for (int k = 0; k < LP_TAPS - 1; k++) begin
      pre_next[k] = 14'(rnew[k]) + 14'(rnew[TAPS - 1 - k]);
    end
    pre_next[LP_TAPS - 1] = 14'(rnew[LP_TAPS - 1]);
    prod     = lp_coef(step) * pre[0];
    acc_next = acc + 29'(prod);
    fout     = 16'(acc_next >>> 16);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      step   <= '0;
      done   <= 1'b0;
      dc_est <= '0;
      for (int k = 0; k < TAPS; k++) begin
        rline[k] <= '0;
        fline[k] <= '0;
      end
    end else begin
      done <= 1'b0;
      if (start) begin
        dc_est <= dc_next;
        rline  <= rnew;
        step   <= '0;
        busy   <= 1'b1;
      end else if (busy) begin
        step <= step + 3'd1;
        if (step == 3'(LP_TAPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
          for (int k = 0; k < TAPS - 1; k++) fline[k] <= fline[k + 1];
          fline[TAPS - 1] <= fout;
        end
      end
    end
  end

  // tap-pair sums shift toward the multiplier
  always_ff @(posedge clk) begin
    if (start) begin
      pre <= pre_next;
      acc <= '0;
    end else if (busy) begin
      acc <= acc_next;
      for (int k = 0; k < LP_TAPS - 1; k++) pre[k] <= pre[k + 1];
      pre[LP_TAPS - 1] <= '0;
    end
  end

endmodule

// ===== rtl/iqssb_merge.sv =====
// ----------------------------------------------------------------------------
// iqssb_merge
// combines both lanes: hilbert, demod, gain or divide, clamp and monitors
// ----------------------------------------------------------------------------
module iqssb_merge (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  clear,
  input  iqssb_pkg::merge_cfg_t cfg,
  input  iqssb_pkg::sample16_t  i_line [iqssb_pkg::TAPS],
  input  iqssb_pkg::sample16_t  q_line [iqssb_pkg::TAPS],
  output logic                  done,
  output iqssb_pkg::merge_res_t res
);
  import iqssb_pkg::*;

  typedef enum logic [6:0] {
    M_IDLE  = 7'b0000001,
    M_HILB  = 7'b0000010,
    M_DEMOD = 7'b0000100,
    M_GAIN  = 7'b0001000,
    M_DIV   = 7'b0010000,
    M_SIGN  = 7'b0100000,
    M_OUT   = 7'b1000000
  } mstate_t;

  mstate_t            state;
  logic [3:0]         step;
  logic signed [16:0] d [HB_TAPS];
  logic signed [31:0] acc;
  logic signed [31:0] acc_next;
  logic signed [32:0] hprod;
  logic signed [15:0] qh;
  logic signed [15:0] a;
  logic signed [15:0] a_demod;
  logic signed [23:0] gprod;
  logic [15:0]        num;
  logic [7:0]         den;
  logic [7:0]         rem;
  logic [8:0]         rem_sh;
  logic               q_ge;
  logic               neg;
  logic [14:0]        in_peak;
  logic [14:0]        out_peak;
  logic               clip_latch;
  logic [14:0]        mi;
  logic [14:0]        mq;
  logic [14:0]        in_peak_next;
  logic [14:0]        om;
  logic [14:0]        out_peak_next;
  logic [16:0]        ai;
  logic [16:0]        aq;
  logic [17:0]        am;
  logic signed [16:0] lvl;
  logic               clip_hi;
  logic               clip_lo;

  always_comb begin
    hprod    = hb_coef(step[1:0]) * d[0];
    acc_next = acc + 32'(hprod);

    ai = i_line[TAPS - 1][15] ? 17'(-17'(i_line[TAPS - 1])) : 17'(i_line[TAPS - 1]);
    aq = q_line[TAPS - 1][15] ? 17'(-17'(q_line[TAPS - 1])) : 17'(q_line[TAPS - 1]);
    if (ai > aq) am = 18'(ai) + ((18'(aq) * 18'd3) >> 3);
    else         am = 18'(aq) + ((18'(ai) * 18'd3) >> 3);

    case (cfg.demod_mode)
      MODE_USB: a_demod = 16'(i_line[7] - qh);
      MODE_LSB: a_demod = 16'(i_line[7] + qh);
      MODE_AM:  a_demod = 16'(am);
      default:  a_demod = '0;
    endcase

    gprod  = a * cfg.gain;
    rem_sh = {rem, num[15]};
    q_ge   = (rem_sh >= {1'b0, den});

    mi = mag_sat16(i_line[TAPS - 1]);
    mq = mag_sat16(q_line[TAPS - 1]);
    in_peak_next = in_peak;
    if (mi > in_peak_next) in_peak_next = mi;
    if (mq > in_peak_next) in_peak_next = mq;

    om            = mag_sat16(a);
    out_peak_next = (om > out_peak) ? om : out_peak;
    lvl           = 17'(a) + DAC_MIDSCALE;
    clip_hi       = (lvl > DAC_TOP);
    clip_lo       = lvl[16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= M_IDLE;
      step       <= '0;
      done       <= 1'b0;
      in_peak    <= '0;
      out_peak   <= '0;
      clip_latch <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        M_IDLE: begin
          if (start) begin
            in_peak <= in_peak_next;
            step    <= '0;
            state   <= M_HILB;
          end
        end
        M_HILB: begin
          step <= step + 4'd1;
          if (step == 4'(HB_TAPS - 1)) state <= M_DEMOD;
        end
        M_DEMOD: state <= M_GAIN;
        M_GAIN: begin
          step <= '0;
          if (cfg.gain[7]) state <= M_DIV;
          else             state <= M_OUT;
        end
        M_DIV: begin
          step <= step + 4'd1;
          if (step == 4'd15) state <= M_SIGN;
        end
        M_SIGN: state <= M_OUT;
        M_OUT: begin
          done       <= 1'b1;
          in_peak    <= clear ? '0 : in_peak;
          out_peak   <= clear ? '0 : out_peak_next;
          clip_latch <= clear ? 1'b0 : (clip_latch | clip_hi | clip_lo);
          state      <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      M_IDLE: begin
        if (start) begin
          acc <= '0;
          for (int k = 0; k < HB_TAPS; k++) begin
            d[k] <= 17'(q_line[2 * k]) - 17'(q_line[TAPS - 1 - 2 * k]);
          end
        end
      end
      M_HILB: begin
        acc <= acc_next;
        for (int k = 0; k < HB_TAPS - 1; k++) d[k] <= d[k + 1];
        d[HB_TAPS - 1] <= '0;
        if (step == 4'(HB_TAPS - 1)) qh <= acc_next[31:16];
      end
      M_DEMOD: a <= a_demod;
      M_GAIN: begin
        if (!cfg.gain[7] && (cfg.gain != 8'sd0)) a <= gprod[15:0];
        neg <= a[15];
        num <= a[15] ? 16'(-a) : 16'(a);
        den <= 8'(-cfg.gain);
        rem <= '0;
      end
      M_DIV: begin
        rem <= q_ge ? 8'(rem_sh - {1'b0, den}) : rem_sh[7:0];
        num <= {num[14:0], q_ge};
      end
      M_SIGN: a <= neg ? 16'(-num) : 16'(num);
      M_OUT: begin
        res.dac_level   <= clip_hi ? 13'(DAC_FULL_SCALE) : (clip_lo ? 13'd0 : lvl[12:0]);
        res.clip_now    <= clip_hi | clip_lo;
        res.clip_seen   <= clip_latch | clip_hi | clip_lo;
        res.input_peak  <= in_peak;
        res.output_peak <= out_peak_next;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/iqssb_checker.sv =====
// ----------------------------------------------------------------------------
// iqssb_checker
// port-level checks of the demodulator, bound to the top level
// ----------------------------------------------------------------------------
`include "iq_ssb_am_demodulator_unit_defines.svh"

module iqssb_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input iqssb_pkg::out_item_t out_item
);
  import iqssb_pkg::*;

  `IQSSB_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_item), "stalled result changed")
  `IQSSB_ASSERT_SAME(a_level_range, clk, rst, out_valid, out_item.dac_level <= 13'(DAC_FULL_SCALE), "dac level above full scale")
  `IQSSB_ASSERT_SAME(a_clip_level, clk, rst, out_valid && out_item.clip_now, out_item.dac_level == 13'd0 || out_item.dac_level == 13'(DAC_FULL_SCALE), "clip without clamped level")
  `IQSSB_ASSERT_SAME(a_clip_sticky, clk, rst, out_valid && out_item.clip_now, out_item.clip_seen, "clip not latched")
  `IQSSB_ASSERT_NEXT(a_one_in_flight, clk, rst, in_valid && in_ready, !in_ready, "second transfer taken while busy")

endmodule

bind iq_ssb_am_demodulator_unit iqssb_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
